@@ design/mpfb_pkg.sv @@
// shared types, codes and helpers for the page framebuffer drawing engine
package mpfb_pkg;

    // command codes on the mode field
    localparam logic [1:0] MODE_PLOT   = 2'd0;
    localparam logic [1:0] MODE_CIRCLE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // pixel colour codes
    localparam logic [1:0] COLOR_NONE   = 2'd0;
    localparam logic [1:0] COLOR_CLEAR  = 2'd1;
    localparam logic [1:0] COLOR_SET    = 2'd2;
    localparam logic [1:0] COLOR_TOGGLE = 2'd3;

    // work kinds handed from front to back
    localparam logic [1:0] KIND_PLOT   = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    // widest store address (16 pages of 256 columns)
    localparam int ADDR_MAX_W = 12;

    // command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = 1;
    localparam int QUEUE_CW    = 2;

    // width of the squared walk terms
    localparam int SQ_W = 18;

    typedef logic [ADDR_MAX_W-1:0] addr_t;

    // one classified command
    typedef struct packed {
        logic [1:0]  kind;
        logic        centre;   // zero radius circle: walk registers reset
        logic        hit;      // pixel or read address lies inside the store
        addr_t       addr;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  r;
        logic [15:0] r_sq;
        logic [1:0]  color;
    } cmd_t;

    // back status seen by the front
    typedef struct packed {
        logic init_busy;
    } back_stat_t;

    // apply a colour to one bit of a frame byte
    function automatic logic [7:0] apply_color(input logic [7:0] data,
                                               input logic [7:0] mask,
                                               input logic [1:0] color);
        logic [7:0] res;
        res = data;
        unique case (color)
            COLOR_CLEAR:  res = data & ~mask;
            COLOR_SET:    res = data | mask;
            COLOR_TOGGLE: res = data ^ mask;
            default:      res = data;
        endcase
        return res;
    endfunction

endpackage

@@ design/mono_page_framebuffer_circle_plot_core.sv @@
// top level of the monochrome page framebuffer drawing engine
//
// Commands arrive on the cmd channel (cmd_valid/cmd_ready) with mode, pos_x,
// pos_y, radius and color; each command yields exactly one beat on the rsp
// channel (rsp_valid/rsp_ready) carrying read_data, which is the addressed
// frame byte for a read and zero for every other command.
// The front classifies a command and computes its store address and r^2 in
// the cycle it is taken; a two entry queue holds up to two commands while
// the back end works, so new commands are taken while a result waits.
// The back end owns the single frame store ram (one write, one registered
// read port), runs one command at a time, and every pixel is a read then a
// write; an off-screen plot or circle point skips the store. The number of
// circle walk steps grows with the radius.
// After reset the back end sweeps every store address to zero it;
// cmd_ready stays low during that sweep.
// A stalled receiver holds the result in the output register; the back end
// then waits with the next result and the queue fills, and cmd_ready drops.
module mono_page_framebuffer_circle_plot_core #(
    parameter int PAGES   = 4,
    parameter int COLUMNS = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [1:0] mode,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic [7:0] radius,
    input  logic [1:0] color,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic [7:0] read_data
);

    logic                 q_full;
    logic                 q_push;
    logic                 q_valid;
    logic                 q_pop;
    mpfb_pkg::cmd_t       q_entry;
    mpfb_pkg::cmd_t       q_head;
    mpfb_pkg::back_stat_t stat;

    // command front
    mpfb_front #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .mode      (mode),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .radius    (radius),
        .color     (color),
        .q_full    (q_full),
        .stat      (stat),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // queue between front and back
    mpfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .entry_in (q_entry),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    // execution back end with the frame store
    mpfb_back #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .read_data (read_data)
    );

endmodule

@@ design/mpfb_ram.sv @@
// generic single write port, single read port ram with registered read
module mpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/mpfb_front.sv @@
// command front: takes beats, classifies them and computes store addresses
module mpfb_front #(
    parameter int PAGES   = 4,
    parameter int COLUMNS = 128
) (
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [1:0]          mode,
    input  logic [7:0]          pos_x,
    input  logic [7:0]          pos_y,
    input  logic [7:0]          radius,
    input  logic [1:0]          color,
    input  logic                q_full,
    input  mpfb_pkg::back_stat_t stat,
    output logic                q_push,
    output mpfb_pkg::cmd_t      q_entry
);

    logic        is_read;
    logic [7:0]  page;
    logic        hit;
    logic [15:0] lin;

    // no beat while the queue is full or the store is being swept after reset
    assign cmd_ready = !q_full && !stat.init_busy;
    assign q_push    = cmd_valid && cmd_ready;

    // page is the row byte for reads, the row divided by eight for pixels
    assign is_read = (mode == mpfb_pkg::MODE_READ);
    assign page    = is_read ? pos_y : {3'b000, pos_y[7:3]};
    assign hit     = ({1'b0, pos_x} < 9'(COLUMNS)) && ({1'b0, page} < 9'(PAGES));
    assign lin     = 16'(page) * 16'(COLUMNS) + 16'(pos_x);

    // classify the command
    always_comb
    begin
        q_entry        = '0;
        q_entry.centre = 1'b0;
        q_entry.hit    = hit;
        q_entry.addr   = lin[mpfb_pkg::ADDR_MAX_W-1:0];
        q_entry.x      = pos_x;
        q_entry.y      = pos_y;
        q_entry.r      = radius;
        q_entry.r_sq   = 16'(radius) * 16'(radius);
        q_entry.color  = color;
        unique case (mode)
            mpfb_pkg::MODE_PLOT:
            begin
                q_entry.kind = mpfb_pkg::KIND_PLOT;
            end
            mpfb_pkg::MODE_CIRCLE:
            begin
                // a zero radius circle is a single centre plot
                if (radius == 8'd0)
                begin
                    q_entry.kind   = mpfb_pkg::KIND_PLOT;
                    q_entry.centre = 1'b1;
                end
                else
                begin
                    q_entry.kind = mpfb_pkg::KIND_CIRCLE;
                end
            end
            mpfb_pkg::MODE_CLEAR:
            begin
                q_entry.kind = mpfb_pkg::KIND_CLEAR;
            end
            default:
            begin
                q_entry.kind = mpfb_pkg::KIND_READ;
            end
        endcase
    end

endmodule

@@ design/mpfb_queue.sv @@
// two entry command queue between front and back
module mpfb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mpfb_pkg::cmd_t entry_in,
    output logic           full,
    output logic           valid,
    output mpfb_pkg::cmd_t head,
    input  logic           pop
);

    mpfb_pkg::cmd_t                   slot_reg [mpfb_pkg::QUEUE_DEPTH];
    logic [mpfb_pkg::QUEUE_PW-1:0]    wr_ptr_reg;
    logic [mpfb_pkg::QUEUE_PW-1:0]    wr_ptr_next;
    logic [mpfb_pkg::QUEUE_PW-1:0]    rd_ptr_reg;
    logic [mpfb_pkg::QUEUE_PW-1:0]    rd_ptr_next;
    logic [mpfb_pkg::QUEUE_CW-1:0]    cnt_reg;
    logic [mpfb_pkg::QUEUE_CW-1:0]    cnt_next;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (cnt_reg == mpfb_pkg::QUEUE_CW'(mpfb_pkg::QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + mpfb_pkg::QUEUE_PW'(do_push);
        rd_ptr_next = rd_ptr_reg + mpfb_pkg::QUEUE_PW'(do_pop);
        cnt_next    = cnt_reg + mpfb_pkg::QUEUE_CW'(do_push)
                      - mpfb_pkg::QUEUE_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

@@ design/mpfb_back.sv @@
// execution back end: pixel read-modify-write, circle walk, store sweep, reads
module mpfb_back #(
    parameter int PAGES   = 4,
    parameter int COLUMNS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  mpfb_pkg::cmd_t       q_head,
    output logic                 q_pop,
    output mpfb_pkg::back_stat_t stat,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [7:0]           read_data
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SQ_W  = mpfb_pkg::SQ_W;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_POINT = 4'd3;
    localparam logic [3:0] S_WRITE = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_CLEAR = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_RESP  = 4'd8;

    logic [3:0]      state_reg, state_next;
    mpfb_pkg::cmd_t  cmd_reg, cmd_next;
    logic [9:0]      walk_a_reg, walk_a_next;
    logic [9:0]      walk_b_reg, walk_b_next;
    logic [SQ_W-1:0] a_sq_reg, a_sq_next;
    logic [SQ_W-1:0] b_sq_reg, b_sq_next;
    logic [2:0]      pt_reg, pt_next;
    logic [AW-1:0]   sweep_reg, sweep_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [7:0]      mask_reg, mask_next;
    logic [7:0]      res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_data_reg, out_data_next;

    logic            ram_we;
    logic [AW-1:0]   ram_wr_addr;
    logic [7:0]      ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic [7:0]      ram_rd_data;

    logic [7:0]      pt_x, pt_y;
    logic [4:0]      pt_page;
    logic            pt_hit;
    logic [13:0]     pt_lin;
    logic [AW-1:0]   pt_addr;
    logic [SQ_W-1:0] a_sq_inc;
    logic [SQ_W-1:0] dist_sq;
    logic            out_free;
    logic            sweep_last;

    // frame store
    mpfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // current circle point in walk order, wrapped to eight bits
    always_comb
    begin
        pt_x = cmd_reg.x;
        pt_y = cmd_reg.y;
        unique case (pt_reg)
            3'd0:
            begin
                pt_x = cmd_reg.x + walk_a_reg[7:0];
                pt_y = cmd_reg.y - walk_b_reg[7:0];
            end
            3'd1:
            begin
                pt_x = cmd_reg.x - walk_a_reg[7:0];
                pt_y = cmd_reg.y - walk_b_reg[7:0];
            end
            3'd2:
            begin
                pt_x = cmd_reg.x - walk_a_reg[7:0];
                pt_y = cmd_reg.y + walk_b_reg[7:0];
            end
            3'd3:
            begin
                pt_x = cmd_reg.x + walk_a_reg[7:0];
                pt_y = cmd_reg.y + walk_b_reg[7:0];
            end
            3'd4:
            begin
                pt_x = cmd_reg.x + walk_b_reg[7:0];
                pt_y = cmd_reg.y + walk_a_reg[7:0];
            end
            3'd5:
            begin
                pt_x = cmd_reg.x + walk_b_reg[7:0];
                pt_y = cmd_reg.y - walk_a_reg[7:0];
            end
            3'd6:
            begin
                pt_x = cmd_reg.x - walk_b_reg[7:0];
                pt_y = cmd_reg.y - walk_a_reg[7:0];
            end
            default:
            begin
                pt_x = cmd_reg.x - walk_b_reg[7:0];
                pt_y = cmd_reg.y + walk_a_reg[7:0];
            end
        endcase
    end

    // point address and on-screen test
    assign pt_page = pt_y[7:3];
    assign pt_hit  = ({1'b0, pt_x} < 9'(COLUMNS)) && (9'(pt_page) < 9'(PAGES));
    assign pt_lin  = 14'(pt_page) * 14'(COLUMNS) + 14'(pt_x);
    assign pt_addr = pt_lin[AW-1:0];

    // walk step terms: (a+1)^2 and the distance against r^2
    assign a_sq_inc = a_sq_reg + SQ_W'({walk_a_reg, 1'b0}) + SQ_W'(1);
    assign dist_sq  = a_sq_inc + b_sq_reg;

    assign out_free   = !out_valid_reg || rsp_ready;
    assign sweep_last = (sweep_reg == AW'(DEPTH - 1));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        walk_a_next    = walk_a_reg;
        walk_b_next    = walk_b_reg;
        a_sq_next      = a_sq_reg;
        b_sq_next      = b_sq_reg;
        pt_next        = pt_reg;
        sweep_next     = sweep_reg;
        addr_next      = addr_reg;
        mask_next      = mask_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_wr_addr    = addr_reg;
        ram_wr_data    = mpfb_pkg::apply_color(ram_rd_data, mask_reg, cmd_reg.color);
        ram_rd_en      = 1'b0;
        ram_rd_addr    = pt_addr;

        unique case (state_reg)
            S_INIT:
            begin
                // zero the store after reset
                ram_we      = 1'b1;
                ram_wr_addr = sweep_reg;
                ram_wr_data = '0;
                sweep_next  = sweep_reg + AW'(1);
                if (sweep_last)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_head;
                    addr_next = q_head.addr[AW-1:0];
                    mask_next = 8'b1 << q_head.y[2:0];
                    res_next  = '0;
                    pt_next   = '0;
                    unique case (q_head.kind)
                        mpfb_pkg::KIND_PLOT:
                        begin
                            if (q_head.centre)
                            begin
                                walk_a_next = '0;
                                walk_b_next = '0;
                            end
                            if (q_head.hit)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = q_head.addr[AW-1:0];
                                state_next  = S_WRITE;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        mpfb_pkg::KIND_CIRCLE:
                        begin
                            walk_a_next = '0;
                            walk_b_next = 10'(q_head.r);
                            a_sq_next   = '0;
                            b_sq_next   = SQ_W'(q_head.r_sq);
                            state_next  = S_CHECK;
                        end
                        mpfb_pkg::KIND_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            if (q_head.hit)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = q_head.addr[AW-1:0];
                            end
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                // keep walking while 2*b^2 >= r^2
                if ({b_sq_reg[SQ_W-2:0], 1'b0} >= SQ_W'(cmd_reg.r_sq))
                begin
                    pt_next    = '0;
                    state_next = S_POINT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_POINT:
            begin
                if (pt_hit)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pt_addr;
                    addr_next   = pt_addr;
                    mask_next   = 8'b1 << pt_y[2:0];
                    state_next  = S_WRITE;
                end
                else if (pt_reg == 3'd7)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    pt_next = pt_reg + 3'd1;
                end
            end
            S_WRITE:
            begin
                // modify the byte read in the previous cycle
                ram_we = (cmd_reg.color != mpfb_pkg::COLOR_NONE);
                if (cmd_reg.kind == mpfb_pkg::KIND_PLOT)
                begin
                    state_next = S_RESP;
                end
                else if (pt_reg == 3'd7)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    pt_next    = pt_reg + 3'd1;
                    state_next = S_POINT;
                end
            end
            S_STEP:
            begin
                // a moves on, or b moves in and a stays
                if (dist_sq > SQ_W'(cmd_reg.r_sq))
                begin
                    walk_b_next = walk_b_reg - 10'd1;
                    b_sq_next   = b_sq_reg - SQ_W'({walk_b_reg, 1'b0}) + SQ_W'(1);
                end
                else
                begin
                    walk_a_next = walk_a_reg + 10'd1;
                    a_sq_next   = a_sq_inc;
                end
                state_next = S_CHECK;
            end
            S_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = sweep_reg;
                ram_wr_data = '0;
                sweep_next  = sweep_reg + AW'(1);
                if (sweep_last)
                begin
                    sweep_next = '0;
                    state_next = S_RESP;
                end
            end
            S_READ:
            begin
                res_next   = cmd_reg.hit ? ram_rd_data : 8'd0;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            pt_reg        <= '0;
            walk_a_reg    <= '0;
            walk_b_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pt_reg        <= pt_next;
            walk_a_reg    <= walk_a_next;
            walk_b_reg    <= walk_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        a_sq_reg     <= a_sq_next;
        b_sq_reg     <= b_sq_next;
        addr_reg     <= addr_next;
        mask_reg     <= mask_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign stat.init_busy = (state_reg == S_INIT);
    assign rsp_valid      = out_valid_reg;
    assign read_data      = out_data_reg;

`ifndef SYNTHESIS
    // squared terms track the walk registers
    a_sq_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (a_sq_reg == SQ_W'(walk_a_reg) * SQ_W'(walk_a_reg)))
        else $error("a squared term out of step with walk_a");

    b_sq_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (b_sq_reg == SQ_W'(walk_b_reg) * SQ_W'(walk_b_reg)))
        else $error("b squared term out of step with walk_b");

    // every modify follows a read of the byte in the cycle before
    rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> $past(ram_rd_en))
        else $error("write-back without a preceding store read");

    // no command may reach the queue during the reset sweep
    init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> !q_valid)
        else $error("command queued while the store is being swept");
`endif

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the page framebuffer drawing engine
`timescale 1ns / 100ps

module tb_top;

    localparam int FB_PAGES   = 4;
    localparam int FB_COLUMNS = 128;
    localparam int FB_BYTES   = FB_PAGES * FB_COLUMNS;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 180;
    localparam int DIR_N = 25;

    // one drawing command as driven on the cmd channel
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] r;
        logic [1:0] color;
    } draw_cmd_t;

    // directed row: command plus an optional hand-typed read_data
    typedef struct packed {
        draw_cmd_t  cmd;
        logic       fixed;
        logic [7:0] value;
    } dir_row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    logic [1:0] mode      = mpfb_pkg::MODE_PLOT;
    logic [7:0] pos_x     = 8'd0;
    logic [7:0] pos_y     = 8'd0;
    logic [7:0] radius    = 8'd0;
    logic [1:0] color     = mpfb_pkg::COLOR_NONE;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic [7:0] read_data;

    // shadow copy of the frame store and the circle walk registers
    logic [7:0] shadow_fb [0:FB_BYTES-1];
    logic [9:0] walk_a;
    logic [9:0] walk_b;

    logic [7:0] pending_bytes [$];
    int mismatch_cnt = 0;
    int stall_cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;

    mono_page_framebuffer_circle_plot_core #(
        .PAGES   (FB_PAGES),
        .COLUMNS (FB_COLUMNS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .mode      (mode),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .radius    (radius),
        .color     (color),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .read_data (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // directed commands: reset contents, extremes, wrap, zero radius, clear
    dir_row_t dir_rows [0:DIR_N-1] = '{
        '{'{mpfb_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd127, 8'd3, 8'd255, mpfb_pkg::COLOR_TOGGLE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_PLOT, 8'd0, 8'd0, 8'd0, mpfb_pkg::COLOR_SET}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_PLOT, 8'd127, 8'd31, 8'd0, mpfb_pkg::COLOR_SET}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b0, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd127, 8'd3, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b0, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd128, 8'd0, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd0, 8'd4, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd255, 8'd255, 8'd255, mpfb_pkg::COLOR_TOGGLE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_PLOT, 8'd127, 8'd31, 8'd0, mpfb_pkg::COLOR_TOGGLE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_PLOT, 8'd0, 8'd0, 8'd0, mpfb_pkg::COLOR_CLEAR}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_PLOT, 8'd5, 8'd9, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_PLOT, 8'd128, 8'd0, 8'd0, mpfb_pkg::COLOR_SET}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_PLOT, 8'd0, 8'd32, 8'd0, mpfb_pkg::COLOR_SET}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_PLOT, 8'd255, 8'd255, 8'd255, mpfb_pkg::COLOR_SET}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_CIRCLE, 8'd64, 8'd16, 8'd0, mpfb_pkg::COLOR_TOGGLE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd64, 8'd2, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b0, 8'h00},
        '{'{mpfb_pkg::MODE_CIRCLE, 8'd64, 8'd16, 8'd10, mpfb_pkg::COLOR_TOGGLE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd74, 8'd2, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b0, 8'h00},
        '{'{mpfb_pkg::MODE_CIRCLE, 8'd2, 8'd2, 8'd5, mpfb_pkg::COLOR_SET}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_CIRCLE, 8'd250, 8'd250, 8'd20, mpfb_pkg::COLOR_SET}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd14, 8'd3, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b0, 8'h00},
        '{'{mpfb_pkg::MODE_CIRCLE, 8'd64, 8'd16, 8'd255, mpfb_pkg::COLOR_SET}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_CLEAR, 8'd255, 8'd255, 8'd255, mpfb_pkg::COLOR_TOGGLE}, 1'b1, 8'h00},
        '{'{mpfb_pkg::MODE_READ, 8'd64, 8'd0, 8'd0, mpfb_pkg::COLOR_NONE}, 1'b1, 8'h00}
    };

    // apply one colour to one pixel, skipping points off the screen
    function automatic void paint_pixel(logic [7:0] px, logic [7:0] py, logic [1:0] c);
        int unsigned pg;
        int unsigned idx;
        logic [7:0] bitmask;
        pg = py >> 3;
        if (px >= FB_COLUMNS || pg >= FB_PAGES)
            return;
        idx = pg * FB_COLUMNS + px;
        bitmask = 8'h01 << py[2:0];
        case (c)
            mpfb_pkg::COLOR_CLEAR:  shadow_fb[idx] = shadow_fb[idx] & ~bitmask;
            mpfb_pkg::COLOR_SET:    shadow_fb[idx] = shadow_fb[idx] | bitmask;
            mpfb_pkg::COLOR_TOGGLE: shadow_fb[idx] = shadow_fb[idx] ^ bitmask;
            default:      ;
        endcase
    endfunction

    // octant walk, eight points per step in fixed order, coordinates mod 256
    function automatic void paint_circle(logic [7:0] cx, logic [7:0] cy, logic [7:0] r,
                                         logic [1:0] c);
        int a;
        int b;
        int rr;
        a = 0;
        b = r;
        rr = r * r;
        if (r == 8'd0)
        begin
            paint_pixel(cx, cy, c);
            walk_a = '0;
            walk_b = '0;
            return;
        end
        while (2 * b * b >= rr)
        begin
            paint_pixel(8'(cx + a), 8'(cy - b), c);
            paint_pixel(8'(cx - a), 8'(cy - b), c);
            paint_pixel(8'(cx - a), 8'(cy + b), c);
            paint_pixel(8'(cx + a), 8'(cy + b), c);
            paint_pixel(8'(cx + b), 8'(cy + a), c);
            paint_pixel(8'(cx + b), 8'(cy - a), c);
            paint_pixel(8'(cx - b), 8'(cy - a), c);
            paint_pixel(8'(cx - b), 8'(cy + a), c);
            a++;
            if (a * a + b * b - rr > 0)
            begin
                b--;
                a--;
            end
        end
        walk_a = 10'(a);
        walk_b = 10'(b);
    endfunction

    function automatic void wipe_shadow();
        for (int i = 0; i < FB_BYTES; i++)
            shadow_fb[i] = 8'h00;
    endfunction

    // update the shadow store and return the read_data the command should give
    function automatic logic [7:0] predict_read_data(draw_cmd_t c);
        logic [7:0] data;
        data = 8'h00;
        case (c.mode)
            mpfb_pkg::MODE_PLOT:   paint_pixel(c.x, c.y, c.color);
            mpfb_pkg::MODE_CIRCLE: paint_circle(c.x, c.y, c.r, c.color);
            mpfb_pkg::MODE_CLEAR:  wipe_shadow();
            default:
            begin
                if (c.y < FB_PAGES && c.x < FB_COLUMNS)
                    data = shadow_fb[c.y * FB_COLUMNS + c.x];
            end
        endcase
        return data;
    endfunction

    // random command, mostly on screen with small radii, some noise
    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int pick;
        c.mode  = mpfb_pkg::MODE_PLOT;
        c.x     = 8'($urandom_range(255));
        c.y     = 8'($urandom_range(255));
        c.r     = 8'($urandom_range(255));
        c.color = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            c.mode = mpfb_pkg::MODE_PLOT;
            if ($urandom_range(9) != 0)
            begin
                c.x = 8'($urandom_range(FB_COLUMNS - 1));
                c.y = 8'($urandom_range(FB_PAGES * 8 - 1));
            end
        end
        else if (pick < 65)
        begin
            c.mode = mpfb_pkg::MODE_CIRCLE;
            if ($urandom_range(9) != 0)
            begin
                c.x = 8'($urandom_range(FB_COLUMNS - 1));
                c.y = 8'($urandom_range(FB_PAGES * 8 - 1));
            end
            pick = $urandom_range(99);
            if (pick < 10)
                c.r = 8'($urandom_range(2));
            else if (pick < 97)
                c.r = 8'($urandom_range(40, 1));
        end
        else if (pick < 68)
            c.mode = mpfb_pkg::MODE_CLEAR;
        else
        begin
            c.mode = mpfb_pkg::MODE_READ;
            if ($urandom_range(6) != 0)
            begin
                c.x = 8'($urandom_range(FB_COLUMNS - 1));
                c.y = 8'($urandom_range(FB_PAGES - 1));
            end
        end
        return c;
    endfunction

    // drive one command beat, predict on acceptance; valid stays up for the next beat
    task automatic send_cmd(draw_cmd_t c, logic fixed, logic [7:0] value);
        logic [7:0] predicted;
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        mode      <= c.mode;
        pos_x     <= c.x;
        pos_y     <= c.y;
        radius    <= c.r;
        color     <= c.color;
        do
            @(posedge clk);
        while (!cmd_ready);
        predicted = predict_read_data(c);
        pending_bytes.push_back(fixed ? value : predicted);
    endtask

    // hold off the sender until every pending result has come back
    task automatic hold_until_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
    endtask

    // result checking, receiver stalls and watchdog
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: result beat with nothing pending, expected none, got %02h",
                         $time, read_data);
                mismatch_cnt++;
            end
            else if (pending_bytes[0] !== read_data)
            begin
                $display("%0t: read_data mismatch, expected %02h, got %02h",
                         $time, pending_bytes[0], read_data);
                mismatch_cnt++;
                void'(pending_bytes.pop_front());
            end
            else
                void'(pending_bytes.pop_front());
        end
        rsp_ready <= ($urandom_range(99) >= recv_idle);

        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        wipe_shadow();
        walk_a = '0;
        walk_b = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        for (int i = 0; i < DIR_N; i++)
            send_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].value);
        hold_until_drained();

        // random part: receiver-heavy idling, sender-heavy idling, then none
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 38 : (ph == 1) ? 47 : 0;
            recv_idle = (ph == 0) ? 47 : (ph == 1) ? 38 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_cmd(random_cmd(), 1'b0, 8'h00);
                if ($urandom_range(59) == 0)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_bytes.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ sim.f @@
design/mpfb_pkg.sv
design/mpfb_ram.sv
design/mpfb_front.sv
design/mpfb_queue.sv
design/mpfb_back.sv
design/mono_page_framebuffer_circle_plot_core.sv
dv/tb_top.sv
